// ===== src/irc_pkg.sv =====
// shared types, register codes and constants for the ir carrier burst classifier
package irc_pkg;

  localparam int DEF_LENGTH_BITS = 24;
  localparam int DEF_TIME_BITS   = 48;

  localparam int SLOT_W      = 16;
  localparam int HDR_W       = 20;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 2;
  localparam int SLOTS_W     = 8;
  localparam int DIVISOR_W   = SLOT_W + 1;

  localparam logic [SLOT_W-1:0] SLOT_RESET       = 16'd562;
  localparam logic [SLOT_W-1:0] PERIOD_MIN_RESET = 16'd25;
  localparam logic [SLOT_W-1:0] PERIOD_MAX_RESET = 16'd33;
  localparam logic [HDR_W-1:0]  HEADER_RESET     = 20'd0;

  localparam int SLOT_PERCENT = 95;
  localparam int PCT_SCALE    = 100;

  localparam logic [SLOTS_W-1:0] GAP_SLOT_LIMIT = 8'd10;
  localparam logic [SLOTS_W-1:0] SLOT_SAT       = 8'd255;

  localparam logic [1:0] KIND_GAP    = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_MARK   = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SLOT       = 2'd0,
    REG_PERIOD_MIN = 2'd1,
    REG_PERIOD_MAX = 2'd2,
    REG_HEADER     = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DECIDE,
    ST_MARK_GO,
    ST_MARK_WAIT,
    ST_GAP_GO,
    ST_GAP_WAIT,
    ST_EMIT_HDR,
    ST_EMIT_MARK,
    ST_EMIT_GAP
  } state_t;

endpackage

// ===== src/irc_div.sv =====
// serial restoring divider giving a slot count saturated to eight bits
module irc_div import irc_pkg::*; #(
  parameter int DIVIDEND_W = DEF_LENGTH_BITS + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [SLOTS_W-1:0]    slots
);

  localparam int CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVIDEND_W-1:0] quo_next;
  logic [DIVISOR_W-1:0]  dsor;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // one quotient bit per cycle
  always_comb begin
    trial    = {rem, quo[DIVIDEND_W-1]};
    diff     = trial - {1'b0, dsor};
    fits     = trial >= {1'b0, dsor};
    rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    quo_next = {quo[DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dsor <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign slots = (|quo[DIVIDEND_W-1:SLOTS_W]) ? SLOT_SAT : quo[SLOTS_W-1:0];

endmodule

// ===== src/ir_carrier_burst_classifier_core.sv =====
// top level of the ir carrier burst classifier
//
// input channel (run_valid/run_ready) takes one run of constant line level per
// transaction: run_level and run_length in samples. the block keeps an absolute
// sample clock and pairs a short high with the following low into one carrier
// period; periods inside the configured bounds grow a burst.
// output channel (frame_valid/frame_ready) gives zero to three frames per run:
// an optional header, a mark and a gap, last_of_run set on the final one.
// a run that yields no frame goes through accept, prep and decide. each
// rounded slot count runs through one shared serial divider, one bit per
// cycle; a mark and a gap share it, the mark divided first. a frame sits in
// an output register; once the last frame of a run is loaded the next run is
// taken even if the receiver still stalls on that frame, and a stalled
// receiver holds the sequencer in its emit step otherwise. reset (rst,
// synchronous) clears the sample clock and burst state and loads the default
// register values. the user makes configuration writes only while idle; the
// block itself does not enforce this.
module ir_carrier_burst_classifier_core import irc_pkg::*; #(
  parameter int LENGTH_BITS = DEF_LENGTH_BITS,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   run_valid,
  output logic                   run_ready,
  input  logic                   run_level,
  input  logic [LENGTH_BITS-1:0] run_length,
  output logic                   frame_valid,
  input  logic                   frame_ready,
  output logic [1:0]             frame_kind,
  output logic [TIME_BITS-1:0]   frame_start,
  output logic [LENGTH_BITS-1:0] frame_length,
  output logic [SLOTS_W-1:0]     slot_count,
  output logic                   last_of_run
);

  // widths for compares and products
  localparam int CMP_W  = LENGTH_BITS + HDR_W;
  localparam int MUL_W  = LENGTH_BITS + SLOT_W + 7;
  localparam int DIV_DW = (LENGTH_BITS > SLOT_W ? LENGTH_BITS : SLOT_W) + 2;
  localparam logic [TIME_BITS-1:0] LEN_MAX_T = TIME_BITS'({LENGTH_BITS{1'b1}});

  // configuration registers
  logic [SLOT_W-1:0] slot_samples;
  logic [SLOT_W-1:0] period_min_samples;
  logic [SLOT_W-1:0] period_max_samples;
  logic [HDR_W-1:0]  header_samples;
  logic [SLOT_W-1:0] slot_eff;

  // sequencer and burst state
  state_t                 state;
  state_t                 state_next;
  logic [TIME_BITS-1:0]   sample_clock;
  logic                   in_burst;
  logic [TIME_BITS-1:0]   burst_begin;
  logic [LENGTH_BITS-1:0] burst_span;
  logic [LENGTH_BITS-1:0] held_len;
  logic                   held_valid;

  // current run
  logic                   lvl;
  logic [LENGTH_BITS-1:0] len;
  logic [TIME_BITS-1:0]   run_start;

  // prep results
  logic                   is_long;
  logic                   period_ok;
  logic [LENGTH_BITS-1:0] span_new;

  // frames planned for this run
  logic                   has_hdr;
  logic                   has_mark;
  logic                   has_gap;
  logic                   gap_cand;
  logic [TIME_BITS-1:0]   hdr_start;
  logic [TIME_BITS-1:0]   mark_start;
  logic [LENGTH_BITS-1:0] mark_len;
  logic [SLOTS_W-1:0]     mark_slots;
  logic [SLOTS_W-1:0]     gap_slots;

  // prep combinational
  logic                   is_long_c;
  logic [LENGTH_BITS:0]   period_c;
  logic                   period_ok_c;
  logic [TIME_BITS-1:0]   since_begin;
  logic [LENGTH_BITS-1:0] span_new_c;

  // decide combinational
  logic                   valid_period_run;
  logic                   close_c;
  logic                   use_new_span;
  logic                   gap_c;
  logic [LENGTH_BITS-1:0] cspan;
  logic                   has_hdr_c;
  logic [LENGTH_BITS-1:0] span_rest;
  logic                   has_mark_c;
  logic                   gap_ok_c;

  // shared divider
  logic                   div_start;
  logic [DIV_DW-1:0]      div_dividend;
  logic [DIVISOR_W-1:0]   div_divisor;
  logic                   div_done;
  logic [SLOTS_W-1:0]     div_slots;
  logic                   out_free;
  logic                   frame_load;

  assign slot_eff = (slot_samples == '0) ? SLOT_W'(1) : slot_samples;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_samples       <= SLOT_RESET;
      period_min_samples <= PERIOD_MIN_RESET;
      period_max_samples <= PERIOD_MAX_RESET;
      header_samples     <= HEADER_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SLOT:       slot_samples       <= cfg_data[SLOT_W-1:0];
        REG_PERIOD_MIN: period_min_samples <= cfg_data[SLOT_W-1:0];
        REG_PERIOD_MAX: period_max_samples <= cfg_data[SLOT_W-1:0];
        REG_HEADER:     header_samples     <= cfg_data[HDR_W-1:0];
        default:        slot_samples       <= slot_samples;
      endcase
    end
  end

  // prep: long-run test (100*len > 95*slot), period sum, span up to this run
  always_comb begin
    is_long_c   = (MUL_W'(len) * MUL_W'(PCT_SCALE)) > (MUL_W'(slot_eff) * MUL_W'(SLOT_PERCENT));
    period_c    = {1'b0, held_len} + {1'b0, len};
    period_ok_c = (CMP_W'(period_c) >= CMP_W'(period_min_samples)) &&
                  (CMP_W'(period_c) <= CMP_W'(period_max_samples));
    since_begin = run_start - burst_begin;
    if (!in_burst) begin
      // a new burst starts at the held high, so the span is that high
      span_new_c = held_len;
    end else if (since_begin > LEN_MAX_T) begin
      span_new_c = '1;
    end else begin
      span_new_c = since_begin[LENGTH_BITS-1:0];
    end
  end

  // decide: what this run does to the burst and which frames follow
  always_comb begin
    valid_period_run = 1'b0;
    close_c          = 1'b0;
    use_new_span     = 1'b0;
    gap_c            = 1'b0;
    if (lvl) begin
      // a high after a held high, or a long high, ends the burst
      close_c      = held_valid ? in_burst : (is_long & in_burst);
      use_new_span = held_valid & in_burst;
    end else if (held_valid && period_ok) begin
      valid_period_run = 1'b1;
    end else begin
      close_c      = in_burst;
      use_new_span = held_valid & in_burst;
      gap_c        = is_long;
    end
    cspan      = use_new_span ? span_new : burst_span;
    has_hdr_c  = close_c && (header_samples != '0) &&
                 (CMP_W'(header_samples) <= CMP_W'(cspan));
    span_rest  = has_hdr_c ? cspan - LENGTH_BITS'(header_samples) : cspan;
    has_mark_c = close_c && (CMP_W'(span_rest) >= CMP_W'(slot_eff));
  end

  assign gap_ok_c = div_slots < GAP_SLOT_LIMIT;
  assign out_free = !frame_valid || frame_ready;
  assign run_ready = (state == ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    frame_load = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (run_valid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (valid_period_run) begin
          state_next = ST_IDLE;
        end else if (has_mark_c) begin
          state_next = ST_MARK_GO;
        end else if (gap_c) begin
          state_next = ST_GAP_GO;
        end else if (has_hdr_c) begin
          state_next = ST_EMIT_HDR;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MARK_GO: begin
        div_start  = 1'b1;
        state_next = ST_MARK_WAIT;
      end
      ST_MARK_WAIT: begin
        if (div_done) begin
          if (gap_cand) begin
            state_next = ST_GAP_GO;
          end else if (has_hdr) begin
            state_next = ST_EMIT_HDR;
          end else begin
            state_next = ST_EMIT_MARK;
          end
        end
      end
      ST_GAP_GO: begin
        div_start  = 1'b1;
        state_next = ST_GAP_WAIT;
      end
      ST_GAP_WAIT: begin
        if (div_done) begin
          if (has_hdr) begin
            state_next = ST_EMIT_HDR;
          end else if (has_mark) begin
            state_next = ST_EMIT_MARK;
          end else if (gap_ok_c) begin
            state_next = ST_EMIT_GAP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMIT_HDR: begin
        if (out_free) begin
          frame_load = 1'b1;
          if (has_mark) begin
            state_next = ST_EMIT_MARK;
          end else if (has_gap) begin
            state_next = ST_EMIT_GAP;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMIT_MARK: begin
        if (out_free) begin
          frame_load = 1'b1;
          state_next = has_gap ? ST_EMIT_GAP : ST_IDLE;
        end
      end
      ST_EMIT_GAP: begin
        if (out_free) begin
          frame_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // burst state and per-run bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_clock <= '0;
      in_burst     <= 1'b0;
      burst_begin  <= '0;
      burst_span   <= '0;
      held_len     <= '0;
      held_valid   <= 1'b0;
      has_hdr      <= 1'b0;
      has_mark     <= 1'b0;
      has_gap      <= 1'b0;
      gap_cand     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (run_valid) begin
            lvl          <= run_level;
            len          <= run_length;
            run_start    <= sample_clock;
            sample_clock <= sample_clock + TIME_BITS'(run_length);
          end
        end
        ST_PREP: begin
          is_long   <= is_long_c;
          period_ok <= period_ok_c;
          span_new  <= span_new_c;
        end
        ST_DECIDE: begin
          // a short high waits for its low; anything else drops it
          if (lvl && !is_long) begin
            held_valid <= 1'b1;
            held_len   <= len;
          end else begin
            held_valid <= 1'b0;
          end
          if (valid_period_run) begin
            if (!in_burst) begin
              in_burst    <= 1'b1;
              burst_begin <= run_start - TIME_BITS'(held_len);
            end
            burst_span <= span_new;
          end else if (close_c) begin
            in_burst   <= 1'b0;
            burst_span <= '0;
          end
          has_hdr    <= has_hdr_c;
          has_mark   <= has_mark_c;
          has_gap    <= 1'b0;
          gap_cand   <= gap_c;
          hdr_start  <= burst_begin;
          mark_start <= has_hdr_c ? burst_begin + TIME_BITS'(header_samples) : burst_begin;
          mark_len   <= span_rest;
        end
        ST_MARK_WAIT: begin
          if (div_done) begin
            mark_slots <= div_slots;
          end
        end
        ST_GAP_WAIT: begin
          if (div_done) begin
            has_gap   <= gap_ok_c;
            gap_slots <= div_slots;
          end
        end
        default: begin
          has_gap <= has_gap;
        end
      endcase
    end
  end

  // rounded slots: (2*len + slot) / (2*slot)
  assign div_dividend = (state == ST_GAP_GO) ?
                        DIV_DW'({len, 1'b0}) + DIV_DW'(slot_eff) :
                        DIV_DW'({mark_len, 1'b0}) + DIV_DW'(slot_eff);
  assign div_divisor  = {slot_eff, 1'b0};

  irc_div #(
    .DIVIDEND_W (DIV_DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .slots    (div_slots)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame_load) begin
      frame_valid <= 1'b1;
      case (state)
        ST_EMIT_HDR: begin
          frame_kind   <= KIND_HEADER;
          frame_start  <= hdr_start;
          frame_length <= LENGTH_BITS'(header_samples);
          slot_count   <= '0;
          last_of_run  <= !has_mark && !has_gap;
        end
        ST_EMIT_MARK: begin
          frame_kind   <= KIND_MARK;
          frame_start  <= mark_start;
          frame_length <= mark_len;
          slot_count   <= mark_slots;
          last_of_run  <= !has_gap;
        end
        default: begin
          frame_kind   <= KIND_GAP;
          frame_start  <= run_start;
          frame_length <= len;
          slot_count   <= gap_slots;
          last_of_run  <= 1'b1;
        end
      endcase
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

endmodule

// ===== tb/ir_carrier_burst_classifier_core_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the ir carrier burst classifier core
module ir_carrier_burst_classifier_core_test;
  import irc_pkg::*;

  localparam int LEN_W = DEF_LENGTH_BITS;
  localparam int TIME_W = DEF_TIME_BITS;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  // allowance for the worst run: two divisions plus three stalled frames
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_RUNS = 45;
  localparam int MIN_PHASE_FRAMES = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // one output frame as seen on the result channel
  typedef struct packed {
    logic [1:0]         kind;
    logic [TIME_W-1:0]  start;
    logic [LEN_W-1:0]   length;
    logic [SLOTS_W-1:0] slots;
    logic               last;
  } frame_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   run_valid;
  logic                   run_ready;
  logic                   run_level;
  logic [LEN_W-1:0]       run_length;
  logic                   frame_valid;
  logic                   frame_ready;
  logic [1:0]             frame_kind;
  logic [TIME_W-1:0]      frame_start;
  logic [LEN_W-1:0]       frame_length;
  logic [SLOTS_W-1:0]     slot_count;
  logic                   last_of_run;

  // register copies used by the predictor
  logic [SLOT_W-1:0] slot_cfg;
  logic [SLOT_W-1:0] pmin_cfg;
  logic [SLOT_W-1:0] pmax_cfg;
  logic [HDR_W-1:0]  header_cfg;

  // predictor state: absolute sample clock, open burst and a short high
  // still waiting for the low that completes its carrier period
  logic [TIME_W-1:0] clock_now;
  logic              burst_open;
  logic [TIME_W-1:0] burst_begin;
  logic [LEN_W-1:0]  burst_span;
  logic              pending_high;
  logic [LEN_W-1:0]  pending_high_len;

  frame_t frames_due[$];  // predicted frames not yet seen on the output
  frame_t run_frames[$];  // frames caused by the run being predicted

  int          runs_sent;
  int          frames_predicted;
  int          frames_checked;
  int          bad_frames;
  int          config_loads;
  int unsigned cycle_count = 0;
  logic        src_lazy;
  logic        sink_lazy;

  ir_carrier_burst_classifier_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .run_valid    (run_valid),
    .run_ready    (run_ready),
    .run_level    (run_level),
    .run_length   (run_length),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame_kind   (frame_kind),
    .frame_start  (frame_start),
    .frame_length (frame_length),
    .slot_count   (slot_count),
    .last_of_run  (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog against a hung handshake
  initial begin : watchdog
    wait (cycle_count > CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d frames still expected",
             cycle_count, frames_due.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // a zero slot register behaves as a one-sample slot
  function automatic longint unsigned eff_slot();
    return (slot_cfg == '0) ? 64'd1 : 64'(slot_cfg);
  endfunction

  // rounded slot count, half rounds up, saturating
  function automatic logic [SLOTS_W-1:0] slots_of(input longint unsigned len);
    longint unsigned s;
    longint unsigned q;
    s = eff_slot();
    q = (2 * len + s) / (2 * s);
    return (q > 64'(SLOT_SAT)) ? SLOT_SAT : q[SLOTS_W-1:0];
  endfunction

  // burst span from the burst start up to t, wrapping clock, saturating length
  function automatic logic [LEN_W-1:0] span_until(input logic [TIME_W-1:0] t);
    logic [TIME_W-1:0] d;
    d = t - burst_begin;
    return (d > TIME_W'(LEN_MAX)) ? LEN_MAX : d[LEN_W-1:0];
  endfunction

  // close the open burst: optional header frame, then mark if a slot remains
  task automatic end_burst();
    logic [TIME_W-1:0] at;
    logic [LEN_W-1:0]  rest;
    at = burst_begin;
    rest = burst_span;
    if (header_cfg != '0 && LEN_W'(header_cfg) <= rest) begin
      run_frames.push_back(frame_t'{KIND_HEADER, at, LEN_W'(header_cfg),
                                    SLOTS_W'(0), 1'b0});
      at = at + TIME_W'(header_cfg);
      rest = rest - LEN_W'(header_cfg);
    end
    if (64'(rest) >= eff_slot())
      run_frames.push_back(frame_t'{KIND_MARK, at, rest, slots_of(64'(rest)), 1'b0});
    burst_open = 1'b0;
    burst_span = '0;
  endtask

  // work out the frames that one accepted run causes
  task automatic classify_run(input logic lvl, input logic [LEN_W-1:0] len);
    logic [TIME_W-1:0] t0;
    longint unsigned   period;
    logic              long_run;
    logic              absorbed;
    t0 = clock_now;
    long_run = 64'(len) * 64'(PCT_SCALE) > 64'(SLOT_PERCENT) * eff_slot();
    absorbed = 1'b0;
    run_frames.delete();
    clock_now = clock_now + TIME_W'(len);
    if (lvl) begin
      // a second high in a row ends the burst at the start of this one
      if (pending_high) begin
        if (burst_open) begin
          burst_span = span_until(t0);
          end_burst();
        end
        pending_high = 1'b0;
      end else if (long_run && burst_open) begin
        end_burst();
      end
      if (!long_run) begin
        pending_high = 1'b1;
        pending_high_len = len;
      end
    end else begin
      if (pending_high) begin
        period = 64'(pending_high_len) + 64'(len);
        pending_high = 1'b0;
        if (period >= 64'(pmin_cfg) && period <= 64'(pmax_cfg)) begin
          // carrier period: burst grows up to the end of its high
          if (!burst_open) begin
            burst_open = 1'b1;
            burst_begin = t0 - TIME_W'(pending_high_len);
          end
          burst_span = span_until(t0);
          absorbed = 1'b1;
        end else if (burst_open) begin
          burst_span = span_until(t0);
          end_burst();
        end
      end else if (burst_open) begin
        end_burst();
      end
      if (!absorbed && long_run && slots_of(64'(len)) < GAP_SLOT_LIMIT)
        run_frames.push_back(frame_t'{KIND_GAP, t0, len, slots_of(64'(len)), 1'b0});
    end
    if (run_frames.size() > 0)
      run_frames[run_frames.size()-1].last = 1'b1;
    foreach (run_frames[i]) frames_due.push_back(run_frames[i]);
    frames_predicted += run_frames.size();
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // send one run; returns at the clock edge where the transaction is accepted
  task automatic send_run(input logic lvl, input logic [LEN_W-1:0] len);
    int gap;
    gap = src_lazy ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      run_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    run_valid <= 1'b1;
    run_level <= lvl;
    run_length <= len;
    do @(posedge clk); while (!run_ready);
    classify_run(lvl, len);
    runs_sent++;
  endtask

  // wait for all frames plus the latency of runs that give none
  task automatic wait_idle();
    run_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers on back-to-back cycles, block idle
  task automatic load_config(input logic [CFG_DATA_W-1:0] slot,
                             input logic [CFG_DATA_W-1:0] pmin,
                             input logic [CFG_DATA_W-1:0] pmax,
                             input logic [CFG_DATA_W-1:0] hdr);
    cfg_write <= 1'b1;
    cfg_index <= REG_SLOT;
    cfg_data <= slot;
    @(posedge clk);
    cfg_index <= REG_PERIOD_MIN;
    cfg_data <= pmin;
    @(posedge clk);
    cfg_index <= REG_PERIOD_MAX;
    cfg_data <= pmax;
    @(posedge clk);
    cfg_index <= REG_HEADER;
    cfg_data <= hdr;
    @(posedge clk);
    cfg_write <= 1'b0;
    slot_cfg = slot[SLOT_W-1:0];
    pmin_cfg = pmin[SLOT_W-1:0];
    pmax_cfg = pmax[SLOT_W-1:0];
    header_cfg = hdr[HDR_W-1:0];
    config_loads++;
  endtask

  function automatic logic [LEN_W-1:0] clip(input longint unsigned v);
    return (v > 64'(LEN_MAX)) ? LEN_MAX : v[LEN_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls, every frame checked against the oldest prediction
  // ---------------------------------------------------------------------------

  task automatic report_bad(input string what, input frame_t want, input frame_t got);
    bad_frames++;
    if (bad_frames <= 10)
      $display("%s at cycle %0d: expected kind %0d start %0d length %0d slots %0d last %0d,",
               what, cycle_count, want.kind, want.start, want.length, want.slots, want.last,
               " got kind %0d start %0d length %0d slots %0d last %0d",
               got.kind, got.start, got.length, got.slots, got.last);
  endtask

  initial begin : frame_sink
    frame_t want;
    frame_t got;
    int     stall;
    frame_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = sink_lazy ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        frame_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frame_ready <= 1'b1;
      do @(posedge clk); while (!frame_valid);
      got = frame_t'{frame_kind, frame_start, frame_length, slot_count, last_of_run};
      frames_checked++;
      if (frames_due.size() == 0) begin
        report_bad("unexpected frame", '0, got);
      end else begin
        want = frames_due.pop_front();
        if (got.kind !== want.kind || got.start !== want.start ||
            got.length !== want.length || got.slots !== want.slots ||
            got.last !== want.last)
          report_bad("frame mismatch", want, got);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // lone runs around the gap threshold and the ten-slot limit, slot of 40
  task automatic test_gap_threshold();
    wait_idle();
    load_config(20'd40, 20'd8, 20'd16, 20'd0);
    send_run(1'b0, 24'd0);
    send_run(1'b0, 24'd1);
    send_run(1'b1, LEN_MAX);   // long high with no burst is dropped
    send_run(1'b0, LEN_MAX);   // far over ten slots, no gap
    send_run(1'b0, 24'd38);    // exactly 95 percent, not long
    send_run(1'b0, 24'd39);    // just over, one-slot gap
    send_run(1'b0, 24'd379);   // rounds to nine slots
    send_run(1'b0, 24'd380);   // rounds to ten slots, dropped
  endtask

  // burst at both period bounds, closed by an invalid period: header and gap, no mark
  task automatic test_burst_with_header();
    wait_idle();
    load_config(20'd40, 20'd8, 20'd16, 20'd8);
    send_run(1'b1, 24'd1);
    send_run(1'b0, 24'd7);
    send_run(1'b1, 24'd8);
    send_run(1'b0, 24'd8);
    send_run(1'b1, 24'd5);
    send_run(1'b0, 24'd5);
    send_run(1'b1, 24'd6);
    send_run(1'b0, 24'd200);
  endtask

  // burst ends by a second high, by a long high and by a low with no high
  task automatic test_burst_closers();
    send_run(1'b1, 24'd5);
    send_run(1'b0, 24'd5);
    send_run(1'b1, 24'd4);
    send_run(1'b1, 24'd4);
    send_run(1'b0, 24'd5);
    send_run(1'b1, 24'd100);
    send_run(1'b1, 24'd3);
    send_run(1'b0, 24'd5);
    send_run(1'b0, 24'd60);
  endtask

  // carrier periods with random content, then a random way to end the burst
  task automatic send_burst();
    longint unsigned slot;
    longint unsigned maxh;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned p;
    longint unsigned hmax;
    longint unsigned h;
    int              cap;
    slot = eff_slot();
    maxh = (64'(SLOT_PERCENT) * slot) / 64'(PCT_SCALE);
    if (maxh < 1) maxh = 1;
    lo = 64'(pmin_cfg);
    hi = 64'(pmax_cfg);
    if (lo > hi || hi < 2) begin
      lo = 2;
      hi = 60;
    end
    if (lo < 2) lo = 2;
    cap = int'((2 * slot) / ((lo + hi) / 2)) + 2;
    if (cap > 40 || $urandom_range(0, 5) == 0) cap = 40;
    repeat ($urandom_range(1, cap)) begin
      p = 64'($urandom_range(int'(lo), int'(hi)));
      hmax = (p - 1 < maxh) ? p - 1 : maxh;
      h = 64'($urandom_range(1, int'(hmax)));
      send_run(1'b1, clip(h));
      send_run(1'b0, clip(p - h));
    end
    case ($urandom_range(0, 4))
      0: send_run(1'b0, clip(64'($urandom_range(1, int'(10 * slot)))));
      1: begin
        // high whose period is above the bounds or a single sample (below a minimum over one)
        send_run(1'b1, 24'd1);
        if ($urandom_range(0, 1) == 1)
          send_run(1'b0, clip(hi + 64'($urandom_range(1, int'(3 * slot)))));
        else
          send_run(1'b0, 24'd0);
      end
      2: send_run(1'b1, clip(maxh + 64'($urandom_range(1, int'(4 * slot)))));
      3: send_run(1'b1, clip(64'($urandom_range(1, int'(maxh)))));
      default: ;
    endcase
  endtask

  // single run of any level and length, reaching every length bit
  task automatic send_noise();
    logic [LEN_W-1:0] len;
    case ($urandom_range(0, 3))
      0: len = LEN_W'($urandom);
      1: len = LEN_W'(1) << $urandom_range(0, LEN_W - 1);
      2: len = clip(64'($urandom_range(0, int'(2 * eff_slot()))));
      default: len = LEN_MAX - LEN_W'($urandom_range(0, 255));
    endcase
    send_run(1'($urandom), len);
  endtask

  task automatic random_phase(input logic [CFG_DATA_W-1:0] slot,
                              input logic [CFG_DATA_W-1:0] pmin,
                              input logic [CFG_DATA_W-1:0] pmax,
                              input logic [CFG_DATA_W-1:0] hdr);
    int first_run;
    int first_frame;
    wait_idle();
    load_config(slot, pmin, pmax, hdr);
    first_run = runs_sent;
    first_frame = frames_predicted;
    while ((runs_sent - first_run < PHASE_RUNS ||
            frames_predicted - first_frame < MIN_PHASE_FRAMES) &&
           runs_sent - first_run < 3 * PHASE_RUNS) begin
      // idling comes and goes so both calm and bursty stretches occur
      src_lazy = ($urandom_range(0, 2) != 0);
      sink_lazy = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 9) < 7)
        send_burst();
      else
        send_noise();
    end
  endtask

  // register settings from the reset values out to the extremes
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] pmin;
    random_phase(20'(SLOT_RESET), 20'(PERIOD_MIN_RESET), 20'(PERIOD_MAX_RESET),
                 20'(HEADER_RESET));
    pmin = 20'($urandom_range(4, 30));
    random_phase(20'($urandom_range(20, 300)), pmin, pmin + 20'($urandom_range(0, 20)),
                 20'($urandom_range(0, 200)));
    random_phase(20'd0, 20'd1, 20'd6, 20'd3);            // zero slot acts as one
    random_phase(20'd65535, 20'd1, 20'd65535, 20'hFFFFF);
    random_phase(20'd100, 20'd40, 20'd20, 20'd0);        // inverted bounds
    random_phase(20'd2, 20'd2, 20'd300, 20'd0);          // slot counts saturate
    pmin = 20'($urandom_range(1, 50));
    random_phase(20'($urandom_range(1, 1000)), pmin, pmin + 20'($urandom_range(0, 100)),
                 20'($urandom_range(0, 600)));
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_SLOT;
    cfg_data <= '0;
    run_valid <= 1'b0;
    run_level <= 1'b0;
    run_length <= '0;
    slot_cfg = SLOT_RESET;
    pmin_cfg = PERIOD_MIN_RESET;
    pmax_cfg = PERIOD_MAX_RESET;
    header_cfg = HEADER_RESET;
    clock_now = '0;
    burst_open = 1'b0;
    burst_begin = '0;
    burst_span = '0;
    pending_high = 1'b0;
    pending_high_len = '0;
    runs_sent = 0;
    frames_predicted = 0;
    frames_checked = 0;
    bad_frames = 0;
    config_loads = 0;
    src_lazy = 1'b1;
    sink_lazy = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_gap_threshold();
    test_burst_with_header();
    test_burst_closers();
    test_random_traffic();

    // drain: nothing left expected, then the latency of a frameless run
    wait_idle();
    $display("sent %0d runs under %0d register settings, checked %0d frames",
             runs_sent, config_loads, frames_checked);
    $display("%0d frame mismatches, %0d cycles", bad_frames, cycle_count);
    if (bad_frames == 0 && frames_due.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
